// File: hdl/pss_pkg.sv
// shared types and constants of the permutation sparse set
`default_nettype none

package pss_pkg;

  // sequencer states
  typedef enum logic [1:0] {
    ST_INIT,   // identity sweep after reset
    ST_IDLE,
    ST_EXEC,   // table data back, result and first swap write
    ST_WR2     // second swap write
  } state_e;

  // command codes of the input transaction
  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_DEL  = 2'd1,
    CMD_TEST = 2'd2,
    CMD_READ = 2'd3
  } cmd_e;

  // register map
  localparam int unsigned REG_UNIVERSE   = 0;
  localparam logic [8:0]  UNIVERSE_RESET = 9'd256;

endpackage

`default_nettype wire

// File: hdl/permutation_sparse_set_top.sv
// permutation sparse set: order and position tables, member count, apb register
`default_nettype none

// channel   direction  handshake                    payload
// cfg       in/out     psel/penable/pwrite, pready  paddr, pwdata, prdata
// in        in         in_valid_i / in_stall_o      command_i, element_i, index_i
// out       out        out_valid_o / out_stall_i    was_member_o, member_count_o,
//                                                   member_value_o, error_o
//
// the accept edge registers the table reads, the execute state forms the result
// and, when a swap is needed, writes its first half, and ST_WR2 writes the second
// half while the next command may already be accepted
// after reset the tables are swept to identity, with no
// input transaction accepted; register writes are taken during the sweep
// a stalled result holds the command in its execute cycle until it drains

module permutation_sparse_set_top #(
  parameter int unsigned MAX_ELEMENTS = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // command channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  command_i,
  input  wire logic [7:0]  element_i,
  input  wire logic [7:0]  index_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             was_member_o,
  output logic [8:0]       member_count_o,
  output logic [7:0]       member_value_o,
  output logic             error_o
);

  // table address, count and compare widths
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  // tables
  logic [AW-1:0] ord_mem [MAX_ELEMENTS];
  logic [AW-1:0] pos_mem [MAX_ELEMENTS];

  pss_pkg::state_e state_q, state_d;
  logic [AW-1:0]   init_q, init_d;
  logic [CW-1:0]   count_q, count_d;
  logic [8:0]      universe_q;

  // command held from accept to execute
  pss_pkg::cmd_e   cmd_q;
  logic [7:0]      elt_q;
  logic [7:0]      idx_q;
  logic [AW-1:0]   p_q;          // target position (or read index)

  // read data and forwarding from the second swap write
  logic [AW-1:0]   ord_rdata_q, pos_rdata_q;
  logic            fwd_ord_q, fwd_pos_q;

  // second half of the swap
  logic [AW-1:0]   pos_w2_q, other_q;

  // result register
  logic            out_valid_q;
  logic            was_q, err_q;
  logic [8:0]      cnt_out_q;
  logic [7:0]      val_q;

  logic            accept, cfg_wr, exec_fire;
  logic [AW-1:0]   ord_raddr, pos_raddr;
  logic            ord_we, pos_we;
  logic [AW-1:0]   ord_waddr, ord_wdata, pos_waddr, pos_wdata;
  logic [AW-1:0]   pos_val, ord_val;
  logic [LW-1:0]   act_u;
  logic            elt_ok, idx_ok, is_member;
  logic            ex_err, ex_was, ex_swap;
  logic [7:0]      ex_value;
  logic [CW-1:0]   ex_count;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    if (paddr[2] == 1'(pss_pkg::REG_UNIVERSE)) begin
      prdata = 32'(universe_q);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      universe_q <= pss_pkg::UNIVERSE_RESET;
    end else if (cfg_wr && (paddr[2] == 1'(pss_pkg::REG_UNIVERSE))) begin
      universe_q <= pwdata[8:0];
    end
  end

  // ---------------------------------------------------------------------------
  // accept and table read addresses
  // ---------------------------------------------------------------------------
  // a new command may enter while the second swap write goes on
  assign in_stall_o = !((state_q == pss_pkg::ST_IDLE) || (state_q == pss_pkg::ST_WR2));
  assign accept     = in_valid_i && !in_stall_o;

  assign pos_raddr = AW'(element_i);

  always_comb begin
    case (pss_pkg::cmd_e'(command_i))
      pss_pkg::CMD_READ: ord_raddr = AW'(index_i);
      pss_pkg::CMD_DEL:  ord_raddr = AW'(count_q - CW'(1));  // last member slot
      default:           ord_raddr = AW'(count_q);           // first free slot
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= pss_pkg::cmd_e'(command_i);
      elt_q     <= element_i;
      idx_q     <= index_i;
      p_q       <= ord_raddr;
      // entries written at this same edge come from the swap registers
      fwd_pos_q <= (state_q == pss_pkg::ST_WR2) && (pos_raddr == other_q);
      fwd_ord_q <= (state_q == pss_pkg::ST_WR2) && (ord_raddr == pos_w2_q);
    end
  end

  // ---------------------------------------------------------------------------
  // tables
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (ord_we) begin
      ord_mem[ord_waddr] <= ord_wdata;
    end
    if (accept) begin
      ord_rdata_q <= ord_mem[ord_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem[pos_waddr] <= pos_wdata;
    end
    if (accept) begin
      pos_rdata_q <= pos_mem[pos_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // execute: result and swap
  // ---------------------------------------------------------------------------
  assign pos_val = fwd_pos_q ? pos_w2_q : pos_rdata_q;
  assign ord_val = fwd_ord_q ? other_q  : ord_rdata_q;

  // limit clamps to the table size; zero rejects everything
  assign act_u  = (LW'(universe_q) < LW'(MAX_ELEMENTS)) ? LW'(universe_q)
                                                        : LW'(MAX_ELEMENTS);
  assign elt_ok    = LW'(elt_q) < act_u;
  assign idx_ok    = LW'(idx_q) < LW'(count_q);
  assign is_member = CW'(pos_val) < count_q;

  always_comb begin
    ex_err   = 1'b0;
    ex_was   = 1'b0;
    ex_swap  = 1'b0;
    ex_value = '0;
    ex_count = count_q;
    case (cmd_q)
      pss_pkg::CMD_READ: begin
        ex_err = !idx_ok;
        if (idx_ok) begin
          ex_value = 8'(ord_val);
        end
      end
      pss_pkg::CMD_ADD: begin
        if (!elt_ok) begin
          ex_err = 1'b1;
        end else begin
          ex_was = is_member;
          if (!is_member) begin
            ex_count = count_q + CW'(1);
            ex_swap  = (pos_val != p_q);
          end
        end
      end
      pss_pkg::CMD_DEL: begin
        if (!elt_ok) begin
          ex_err = 1'b1;
        end else begin
          ex_was = is_member;
          if (is_member) begin
            ex_count = count_q - CW'(1);
            ex_swap  = (pos_val != p_q);
          end
        end
      end
      pss_pkg::CMD_TEST: begin
        if (!elt_ok) begin
          ex_err = 1'b1;
        end else begin
          ex_was = is_member;
        end
      end
      default: begin
        ex_err = 1'b1;
      end
    endcase
  end

  // execute waits while the result register is full and stalled
  assign exec_fire = (state_q == pss_pkg::ST_EXEC) && !(out_valid_q && out_stall_i);

  // ---------------------------------------------------------------------------
  // sequencer: next state and table write port
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    init_d    = init_q;
    count_d   = count_q;
    ord_we    = 1'b0;
    pos_we    = 1'b0;
    ord_waddr = init_q;
    ord_wdata = init_q;
    pos_waddr = init_q;
    pos_wdata = init_q;
    case (state_q)
      pss_pkg::ST_INIT: begin
        // entry i gets i in both tables
        ord_we = 1'b1;
        pos_we = 1'b1;
        init_d = init_q + AW'(1);
        if (init_q == AW'(MAX_ELEMENTS - 1)) begin
          state_d = pss_pkg::ST_IDLE;
        end
      end
      pss_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pss_pkg::ST_EXEC;
        end
      end
      pss_pkg::ST_EXEC: begin
        if (exec_fire) begin
          count_d = ex_count;
          if (ex_swap) begin
            // element into the target slot
            ord_we    = 1'b1;
            ord_waddr = p_q;
            ord_wdata = AW'(elt_q);
            pos_we    = 1'b1;
            pos_waddr = AW'(elt_q);
            pos_wdata = p_q;
            state_d   = pss_pkg::ST_WR2;
          end else begin
            state_d = pss_pkg::ST_IDLE;
          end
        end
      end
      pss_pkg::ST_WR2: begin
        // displaced element into the old slot of the moved one
        ord_we    = 1'b1;
        ord_waddr = pos_w2_q;
        ord_wdata = other_q;
        pos_we    = 1'b1;
        pos_waddr = other_q;
        pos_wdata = pos_w2_q;
        state_d   = accept ? pss_pkg::ST_EXEC : pss_pkg::ST_IDLE;
      end
      default: begin
        state_d = pss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pss_pkg::ST_INIT;
      init_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      init_q  <= init_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      pos_w2_q <= pos_val;
      other_q  <= ord_val;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      was_q     <= ex_was;
      err_q     <= ex_err;
      cnt_out_q <= 9'(ex_count);
      val_q     <= ex_value;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_member_o   = was_q;
  assign error_o        = err_q;
  assign member_count_o = cnt_out_q;
  assign member_value_o = val_q;

`ifndef ASSERT_OFF
  // the count never runs past the table size
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(MAX_ELEMENTS))
    else $error("member count above table size");

  // a result appears only out of an execute cycle
  a_out_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pss_pkg::ST_EXEC))
    else $error("result without execute");

  // the count moves only when a command executes
  a_count_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(count_q) |-> $past(state_q == pss_pkg::ST_EXEC))
    else $error("count changed outside execute");

  // the second swap write always follows an execute cycle
  a_wr2_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pss_pkg::ST_WR2) |-> $past(state_q == pss_pkg::ST_EXEC))
    else $error("second swap write without execute");
`endif

endmodule

`default_nettype wire
